### sv/push_to_talk_touch_qualifier_top_macros.svh
// ---------------------------------------------------------------------------
// Push-to-talk touch qualifier assertion macros
// Concurrent check wrappers, compiled out when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef PUSH_TO_TALK_TOUCH_QUALIFIER_TOP_MACROS_SVH
`define PUSH_TO_TALK_TOUCH_QUALIFIER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted
`define PTTQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pttq check failed");
// Next-cycle implication, disabled while reset is asserted
`define PTTQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pttq check failed");
`else
`define PTTQ_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PTTQ_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

### sv/pttq_pkg.sv
// ---------------------------------------------------------------------------
// pttq_pkg
// Types, codes and reset values of the push-to-talk touch qualifier.
// ---------------------------------------------------------------------------
`default_nettype none

package pttq_pkg;

	// Field widths
	localparam int unsigned TimeW  = 32;
	localparam int unsigned HoldW  = 16;
	localparam int unsigned MaxW   = 24;
	localparam int unsigned CfgW   = 24;
	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned InDataW  = 40;
	localparam int unsigned OutDataW = 40;

	// Register reset values
	localparam logic [HoldW-1:0] MinHoldRst = 16'd200;
	localparam logic [HoldW-1:0] GraceRst   = 16'd80;
	localparam logic [MaxW-1:0]  MaxRecRst  = 24'd30000;

	// Register indexes
	localparam logic [CfgIdxW-1:0] REG_MIN_HOLD  = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_GRACE     = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_MAX_REC   = 2'd2;

	// Qualifier phases, one-hot
	typedef enum logic [4:0] {
		PH_IDLE      = 5'b00001,
		PH_PENDING   = 5'b00010,
		PH_RECORDING = 5'b00100,
		PH_RELEASING = 5'b01000,
		PH_BLOCKED   = 5'b10000
	} phase_t;

	// Event codes
	typedef enum logic [2:0] {
		EV_NONE  = 3'd0,
		EV_TAP   = 3'd1,
		EV_START = 3'd2,
		EV_ABORT = 3'd3,
		EV_STOP  = 3'd4
	} event_t;

endpackage

`default_nettype wire

### sv/push_to_talk_touch_qualifier_top.sv
// A poll accepted into the input register passes through the phase logic and is
// loaded into the result register, whose contents drive m_tdata.
// Throughput: one poll per cycle while m_tready is high; the input register feeds
// the phase logic, whose single pass (32-bit subtracts and compares) loads the
// result register, and a result left waiting holds the input register.
// Reset: phase to idle, timestamps to zero, registers to 200/80/30000 ms; both
// data stages emptied.
`default_nettype none

`include "push_to_talk_touch_qualifier_top_macros.svh"

// ---------------------------------------------------------------------------
// push_to_talk_touch_qualifier_top
// Turns polled touch levels with timestamps into tap/start/abort/stop events.
// ---------------------------------------------------------------------------
module push_to_talk_touch_qualifier_top
	import pttq_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// configuration write channel
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CfgIdxW-1:0]   cfg_index,
	input  wire logic [CfgW-1:0]      cfg_data,
	// poll input
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [InDataW-1:0]   s_tdata,   // [0] touch_down, [32:1] time_ms, rest zero
	// result output
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [OutDataW-1:0]       m_tdata    // [2:0] event_res, [3] recording,
	                                             // [35:4] recording_elapsed_ms, rest zero
);

	// Configuration registers
	logic [HoldW-1:0] min_hold_q;
	logic [HoldW-1:0] grace_q;
	logic [MaxW-1:0]  max_rec_q;

	// Input stage
	logic             valid_s1;
	logic             down_s1;
	logic [TimeW-1:0] time_s1;

	// Qualifier state
	phase_t           phase_q;
	logic [TimeW-1:0] entry_q;
	logic [TimeW-1:0] start_q;

	// Result register
	logic             out_valid_q;
	event_t           out_event_q;
	logic             out_rec_q;
	logic [TimeW-1:0] out_elapsed_q;

	// Next-state logic
	phase_t           phase_nxt;
	logic [TimeW-1:0] entry_nxt;
	logic [TimeW-1:0] start_nxt;
	event_t           ev_nxt;
	logic             rec_nxt;
	logic [TimeW-1:0] elapsed_nxt;
	logic [TimeW-1:0] d_entry;
	logic [TimeW-1:0] d_rec;
	logic             adv;

	assign cfg_ready = 1'b1;

	// Write configuration registers; unused index is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_hold_q <= MinHoldRst;
			grace_q    <= GraceRst;
			max_rec_q  <= MaxRecRst;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MIN_HOLD: min_hold_q <= cfg_data[HoldW-1:0];
				REG_GRACE:    grace_q    <= cfg_data[HoldW-1:0];
				REG_MAX_REC:  max_rec_q  <= cfg_data[MaxW-1:0];
				default: ;
			endcase
		end
	end

	// Advance the held poll when the result register is free or being drained
	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	// Hold the accepted poll
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			down_s1 <= s_tdata[0];
			time_s1 <= s_tdata[TimeW:1];
		end
	end

	// Wrapped time differences
	assign d_entry = time_s1 - entry_q;
	assign d_rec   = time_s1 - start_q;

	// Phase transitions and event
	always_comb begin
		phase_nxt = phase_q;
		entry_nxt = entry_q;
		start_nxt = start_q;
		ev_nxt    = EV_NONE;
		unique case (phase_q)
			PH_PENDING: begin
				if (!down_s1) begin
					phase_nxt = PH_IDLE;
					entry_nxt = time_s1;
					ev_nxt    = EV_TAP;
				end else if (d_entry >= {{(TimeW-HoldW){1'b0}}, min_hold_q}) begin
					phase_nxt = PH_RECORDING;
					entry_nxt = time_s1;
					start_nxt = time_s1;
					ev_nxt    = EV_START;
				end
			end
			PH_RECORDING: begin
				// abort check takes priority over loss of contact
				if (d_rec >= {{(TimeW-MaxW){1'b0}}, max_rec_q}) begin
					phase_nxt = PH_BLOCKED;
					entry_nxt = time_s1;
					ev_nxt    = EV_ABORT;
				end else if (!down_s1) begin
					phase_nxt = PH_RELEASING;
					entry_nxt = time_s1;
				end
			end
			PH_RELEASING: begin
				if (down_s1) begin
					phase_nxt = PH_RECORDING;
					entry_nxt = time_s1;
				end else if (d_entry >= {{(TimeW-HoldW){1'b0}}, grace_q}) begin
					phase_nxt = PH_IDLE;
					entry_nxt = time_s1;
					ev_nxt    = EV_STOP;
				end
			end
			PH_BLOCKED: begin
				if (!down_s1) begin
					phase_nxt = PH_IDLE;
					entry_nxt = time_s1;
				end
			end
			default: begin
				if (down_s1) begin
					phase_nxt = PH_PENDING;
					entry_nxt = time_s1;
				end
			end
		endcase
		rec_nxt     = (phase_nxt == PH_RECORDING) || (phase_nxt == PH_RELEASING);
		elapsed_nxt = rec_nxt ? (time_s1 - start_nxt) : '0;
	end

	// Update qualifier state once per poll
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			entry_q <= '0;
			start_q <= '0;
		end else if (adv) begin
			phase_q <= phase_nxt;
			entry_q <= entry_nxt;
			start_q <= start_nxt;
		end
	end

	// Result register: load on advance, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_event_q   <= ev_nxt;
			out_rec_q     <= rec_nxt;
			out_elapsed_q <= elapsed_nxt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OutDataW-TimeW-4){1'b0}}, out_elapsed_q, out_rec_q, out_event_q};

	// Checks
	`PTTQ_ASSERT_IMP(a_start_rec, clk, arst_n,
		out_valid_q && out_event_q == EV_START, out_rec_q && out_elapsed_q == '0)
	`PTTQ_ASSERT_IMP(a_end_idle, clk, arst_n,
		out_valid_q && (out_event_q == EV_ABORT || out_event_q == EV_STOP ||
		out_event_q == EV_TAP), !out_rec_q)
	`PTTQ_ASSERT_IMP(a_norec_zero, clk, arst_n,
		out_valid_q && !out_rec_q, out_elapsed_q == '0)
	`PTTQ_ASSERT_NXT(a_blocked_exit, clk, arst_n,
		phase_q == PH_BLOCKED, phase_q == PH_BLOCKED || phase_q == PH_IDLE)

endmodule

`default_nettype wire
